@@ rtl/core/dmpid_pkg.sv @@
// ---------------------------------------------------------------------------
// dmpid_pkg: shared constants and helpers for the dual-mode PID step
// Field widths, fixed-point format, register map and the symmetric clamp.
// ---------------------------------------------------------------------------
package dmpid_pkg;

  localparam int SAMPLE_W = 16;              // measured / target width
  localparam int ERR_W    = SAMPLE_W + 1;    // target - measured
  localparam int DIFF_W   = SAMPLE_W + 3;    // widest error difference
  localparam int GAIN_W   = 32;              // signed Q16.16 gains
  localparam int FRAC_W   = 16;              // fractional bits of every term
  localparam int LIMIT_W  = 15;              // output / integral limit registers
  localparam int GATE_W   = 16;              // ceiling / dead band registers
  localparam int LIM_W    = LIMIT_W + FRAC_W;
  localparam int PROD_W   = GAIN_W + DIFF_W;
  localparam int ACC_W    = PROD_W + 3;      // room for the sum of four terms
  localparam int STATE_W  = 34;              // integral and incremental state
  localparam int DRIVE_W  = 16;

  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int OUT_DATA_W = DRIVE_W;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_OUT_LIM   = 3'd1;
  localparam logic [2:0] REG_INT_LIM   = 3'd2;
  localparam logic [2:0] REG_GAIN_P    = 3'd3;
  localparam logic [2:0] REG_GAIN_I    = 3'd4;
  localparam logic [2:0] REG_GAIN_D    = 3'd5;
  localparam logic [2:0] REG_ERR_CEIL  = 3'd6;
  localparam logic [2:0] REG_DEAD_BAND = 3'd7;

  localparam logic MODE_POS = 1'b0;
  localparam logic MODE_INC = 1'b1;

  localparam logic [LIMIT_W-1:0] OUT_LIM_RST = 15'd30000;
  localparam logic [LIMIT_W-1:0] INT_LIM_RST = 15'd5000;

  typedef logic signed [ACC_W-1:0] acc_t;

  // clamp v to [-lim, +lim]
  function automatic acc_t clamp_sym(input acc_t v, input logic [LIM_W-1:0] lim);
    acc_t hi;
    acc_t lo;
    hi = $signed({{(ACC_W-LIM_W){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      clamp_sym = hi;
    end else if (v < lo) begin
      clamp_sym = lo;
    end else begin
      clamp_sym = v;
    end
  endfunction

endpackage

@@ rtl/core/dual_mode_pid_step_top.sv @@
// ---------------------------------------------------------------------------
// dual_mode_pid_step_top: positional / incremental PID step
// Error, gating, gain products and state update in a short pipeline,
// followed by a four-entry result queue.
// ---------------------------------------------------------------------------
// channel  | ports                         | payload
// input    | in_tvalid/in_tready/in_tdata  | measured [15:0], target [31:16]
// result   | out_tvalid/out_tready/out_*   | tdata: drive [15:0]; tuser: gated
// config   | cfg_psel..cfg_pready          | eight 32-bit registers at 4*index
//
// One sample per cycle sustained while the result side accepts results; a
// result passes through the input register, the product register and the
// result queue before it is offered. The integral and incremental-output
// loop closes through add and clamp logic after the registered gain products.
// in_tready holds low while four samples are in flight or queued, so a stall
// on the result side backs up into the input after four transfers.
// Reset (rst_n low, synchronous) clears the state, the queue and the registers.
// ---------------------------------------------------------------------------
module dual_mode_pid_step_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dmpid_pkg::IN_DATA_W-1:0]  in_tdata,   // measured, target
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dmpid_pkg::OUT_DATA_W-1:0] out_tdata,  // drive
  output logic                            out_tuser,  // gated
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dmpid_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [dmpid_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [dmpid_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import dmpid_pkg::*;

  localparam int CREDITS = 4;
  localparam int CNT_W   = $clog2(CREDITS + 1);
  localparam int PTR_W   = $clog2(CREDITS);

  // configuration
  logic                     mode_r;
  logic [LIMIT_W-1:0]       out_lim_r;
  logic [LIMIT_W-1:0]       int_lim_r;
  logic signed [GAIN_W-1:0] gain_p_r;
  logic signed [GAIN_W-1:0] gain_i_r;
  logic signed [GAIN_W-1:0] gain_d_r;
  logic [GATE_W-1:0]        err_ceil_r;
  logic [GATE_W-1:0]        dead_band_r;
  logic                     cfg_wr;
  logic [2:0]               cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_POS;
      out_lim_r   <= OUT_LIM_RST;
      int_lim_r   <= INT_LIM_RST;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      err_ceil_r  <= '0;
      dead_band_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:      mode_r      <= cfg_pwdata[0];
        REG_OUT_LIM:   out_lim_r   <= cfg_pwdata[LIMIT_W-1:0];
        REG_INT_LIM:   int_lim_r   <= cfg_pwdata[LIMIT_W-1:0];
        REG_GAIN_P:    gain_p_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_ERR_CEIL:  err_ceil_r  <= cfg_pwdata[GATE_W-1:0];
        REG_DEAD_BAND: dead_band_r <= cfg_pwdata[GATE_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:      cfg_prdata = {{(DATA_W-1){1'b0}}, mode_r};
      REG_OUT_LIM:   cfg_prdata = {{(DATA_W-LIMIT_W){1'b0}}, out_lim_r};
      REG_INT_LIM:   cfg_prdata = {{(DATA_W-LIMIT_W){1'b0}}, int_lim_r};
      REG_GAIN_P:    cfg_prdata = gain_p_r;
      REG_GAIN_I:    cfg_prdata = gain_i_r;
      REG_GAIN_D:    cfg_prdata = gain_d_r;
      REG_ERR_CEIL:  cfg_prdata = {{(DATA_W-GATE_W){1'b0}}, err_ceil_r};
      REG_DEAD_BAND: cfg_prdata = {{(DATA_W-GATE_W){1'b0}}, dead_band_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // credit counter: samples accepted and not yet delivered
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             in_xfer;
  logic             out_xfer;

  assign in_tready = (cnt_r < CNT_W'(CREDITS));
  assign in_xfer   = in_tvalid & in_tready;
  assign out_xfer  = out_tvalid & out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer && !out_xfer) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!in_xfer && out_xfer) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // stage 1: input register
  logic                v1_r;
  logic [SAMPLE_W-1:0] meas_r;
  logic [SAMPLE_W-1:0] tgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      meas_r <= in_tdata[SAMPLE_W-1:0];
      tgt_r  <= in_tdata[IN_DATA_W-1:SAMPLE_W];
    end
  end

  // error, gating and gain products
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         err_mag;
  logic                     gate;
  logic signed [ERR_W-1:0]  e1_r;
  logic signed [ERR_W-1:0]  e2_r;
  logic signed [DIFF_W-1:0] err_x;
  logic signed [DIFF_W-1:0] d1_x;
  logic signed [DIFF_W-1:0] d2_x;
  logic signed [DIFF_W-1:0] op_p;
  logic signed [DIFF_W-1:0] op_d;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;

  always_comb begin
    err     = {tgt_r[SAMPLE_W-1], tgt_r} - {meas_r[SAMPLE_W-1], meas_r};
    err_mag = err[ERR_W-1] ? -err : err;
    gate    = ((err_ceil_r != '0) && (err_mag > {1'b0, err_ceil_r})) ||
              ((dead_band_r != '0) && (err_mag < {1'b0, dead_band_r}));
    err_x   = {{(DIFF_W-ERR_W){err[ERR_W-1]}}, err};
    d1_x    = err_x - {{(DIFF_W-ERR_W){e1_r[ERR_W-1]}}, e1_r};
    d2_x    = d1_x - {{(DIFF_W-ERR_W){e1_r[ERR_W-1]}}, e1_r}
              + {{(DIFF_W-ERR_W){e2_r[ERR_W-1]}}, e2_r};
    op_p    = (mode_r == MODE_INC) ? d1_x : err_x;
    op_d    = (mode_r == MODE_INC) ? d2_x : d1_x;
    prod_p  = gain_p_r * op_p;
    prod_i  = gain_i_r * err_x;
    prod_d  = gain_d_r * op_d;
  end

  // error history shifts on every ungated sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r <= '0;
      e2_r <= '0;
    end else if (v1_r && !gate) begin
      e1_r <= err;
      e2_r <= e1_r;
    end
  end

  // stage 2: registered products
  logic                     v2_r;
  logic                     g2_r;
  logic signed [PROD_W-1:0] pp_r;
  logic signed [PROD_W-1:0] pi_r;
  logic signed [PROD_W-1:0] pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      g2_r <= gate;
      pp_r <= prod_p;
      pi_r <= prod_i;
      pd_r <= prod_d;
    end
  end

  // integral / incremental loop and final clamp
  logic signed [STATE_W-1:0] integ_r;
  logic signed [STATE_W-1:0] pout_r;
  logic [LIM_W-1:0]          ilim;
  logic [LIM_W-1:0]          olim;
  acc_t                      pp_x;
  acc_t                      pi_x;
  acc_t                      pd_x;
  acc_t                      integ_x;
  acc_t                      pout_x;
  acc_t                      i_sum;
  acc_t                      i_new;
  acc_t                      total;
  acc_t                      res;
  acc_t                      res_mag;
  logic [DRIVE_W-1:0]        ip;
  logic [DRIVE_W-1:0]        drive;

  always_comb begin
    ilim    = {int_lim_r, {FRAC_W{1'b0}}};
    olim    = {out_lim_r, {FRAC_W{1'b0}}};
    pp_x    = {{(ACC_W-PROD_W){pp_r[PROD_W-1]}}, pp_r};
    pi_x    = {{(ACC_W-PROD_W){pi_r[PROD_W-1]}}, pi_r};
    pd_x    = {{(ACC_W-PROD_W){pd_r[PROD_W-1]}}, pd_r};
    integ_x = {{(ACC_W-STATE_W){integ_r[STATE_W-1]}}, integ_r};
    pout_x  = {{(ACC_W-STATE_W){pout_r[STATE_W-1]}}, pout_r};
    i_sum   = (mode_r == MODE_INC) ? pi_x : (integ_x + pi_x);
    i_new   = clamp_sym(i_sum, ilim);
    total   = pp_x + i_new + pd_x;
    if (mode_r == MODE_INC) begin
      total = total + pout_x;
    end
    res     = clamp_sym(total, olim);
    // truncate toward zero
    res_mag = res[ACC_W-1] ? -res : res;
    ip      = res_mag[FRAC_W+DRIVE_W-1:FRAC_W];
    drive   = res[ACC_W-1] ? -ip : ip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      pout_r  <= '0;
    end else if (v2_r && !g2_r) begin
      integ_r <= i_new[STATE_W-1:0];
      if (mode_r == MODE_INC) begin
        pout_r <= res[STATE_W-1:0];
      end
    end
  end

  // result queue
  logic [DRIVE_W:0]  q_mem [CREDITS];
  logic [PTR_W:0]    wr_ptr_r;
  logic [PTR_W:0]    rd_ptr_r;
  logic [DRIVE_W:0]  q_rd;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      q_mem[wr_ptr_r[PTR_W-1:0]] <= g2_r ? {1'b1, {DRIVE_W{1'b0}}} : {1'b0, drive};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (v2_r) begin
        wr_ptr_r <= wr_ptr_r + (PTR_W+1)'(1);
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + (PTR_W+1)'(1);
      end
    end
  end

  assign q_rd       = q_mem[rd_ptr_r[PTR_W-1:0]];
  assign out_tvalid = (wr_ptr_r != rd_ptr_r);
  assign out_tdata  = q_rd[DRIVE_W-1:0];
  assign out_tuser  = q_rd[DRIVE_W];

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CREDITS))
    else $error("credit counter above queue depth");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) <= (PTR_W+1)'(cnt_r))
    else $error("queue holds more results than samples in flight");

  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("gated result with nonzero drive");

  a_gate_holds_history: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && gate |=> $stable(e1_r) && $stable(e2_r))
    else $error("error history moved on a gated sample");

  a_gate_holds_integral: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && g2_r |=> $stable(integ_r) && $stable(pout_r))
    else $error("loop state moved on a gated sample");
`endif

endmodule

@@ sim/dual_mode_pid_step_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dual_mode_pid_step_top_tb: self-checking bench for the dual-mode PID step
// Walks a directed table of register writes and samples, then runs random
// phases of register settings and samples with bursty input and a stalling
// result side. Every result is checked against a table value or an in-bench PID predictor.
// ---------------------------------------------------------------------------
module dual_mode_pid_step_top_tb;
  import dmpid_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      gated;
  } pid_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [2:0]                 reg_idx;
    logic [DATA_W-1:0]          reg_val;
    logic signed [SAMPLE_W-1:0] meas;
    logic signed [SAMPLE_W-1:0] tgt;
    bit                         has_exp;
    pid_result_t                res;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    out_tuser;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [ADDR_W-1:0]       cfg_paddr;
  logic [DATA_W-1:0]       cfg_pwdata;
  logic [DATA_W-1:0]       cfg_prdata;
  logic                    cfg_pready;

  // predictor copy of registers and loop state
  logic   m_mode      = MODE_POS;
  longint m_out_lim   = 30000;
  longint m_int_lim   = 5000;
  longint m_gain_p    = 0;
  longint m_gain_i    = 0;
  longint m_gain_d    = 0;
  longint m_err_ceil  = 0;
  longint m_dead_band = 0;
  longint m_err_1     = 0;
  longint m_err_2     = 0;
  longint m_int_acc   = 0;
  longint m_inc_out   = 0;

  pid_result_t expected_results[$];
  stim_row_t   stim_rows[$];
  pid_result_t want;
  int          fail_count  = 0;
  int          burst_left  = 0;
  int          quiet_cycles = 0;
  int          rcv_cycle   = 0;

  dual_mode_pid_step_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // measured [15:0], target [31:16]
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // drive [15:0]
    .out_tuser   (out_tuser),   // gated [0]
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint bound_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Products stay below 2^50 and sums below 2^53, so plain 64-bit math never
  // reaches the saturation points.
  function automatic pid_result_t predict_drive(input logic signed [SAMPLE_W-1:0] meas,
                                                input logic signed [SAMPLE_W-1:0] tgt);
    longint      err;
    longint      mag;
    longint      olim;
    longint      ilim;
    longint      total;
    longint      ip;
    pid_result_t res;
    err       = longint'(tgt) - longint'(meas);
    mag       = (err < 0) ? -err : err;
    olim      = m_out_lim * (longint'(1) << FRAC_W);
    ilim      = m_int_lim * (longint'(1) << FRAC_W);
    res.drive = '0;
    res.gated = 1'b1;
    if ((m_err_ceil != 0 && mag > m_err_ceil) || (m_dead_band != 0 && mag < m_dead_band))
      return res;
    if (m_mode == MODE_POS) begin
      m_int_acc = bound_sym(m_int_acc + m_gain_i * err, ilim);
      total = bound_sym(m_gain_p * err + m_int_acc + m_gain_d * (err - m_err_1), olim);
    end else begin
      // incremental: the clamped I term replaces the accumulator
      m_int_acc = bound_sym(m_gain_i * err, ilim);
      total = bound_sym(m_inc_out + m_gain_p * (err - m_err_1) + m_int_acc
                        + m_gain_d * (err - 2 * m_err_1 + m_err_2), olim);
      m_inc_out = total;
    end
    m_err_2 = m_err_1;
    m_err_1 = err;
    // truncate toward zero
    ip = ((total < 0) ? -total : total) >> FRAC_W;
    if (total < 0) ip = -ip;
    res.drive = ip[DRIVE_W-1:0];
    res.gated = 1'b0;
    return res;
  endfunction

  function automatic void set_model_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_MODE:      m_mode      = val[0];
      REG_OUT_LIM:   m_out_lim   = longint'(val[LIMIT_W-1:0]);
      REG_INT_LIM:   m_int_lim   = longint'(val[LIMIT_W-1:0]);
      REG_GAIN_P:    m_gain_p    = longint'($signed(val));
      REG_GAIN_I:    m_gain_i    = longint'($signed(val));
      REG_GAIN_D:    m_gain_d    = longint'($signed(val));
      REG_ERR_CEIL:  m_err_ceil  = longint'(val[GATE_W-1:0]);
      REG_DEAD_BAND: m_dead_band = longint'(val[GATE_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic void add_sample(input int meas, input int tgt);
    stim_row_t row;
    row         = '{kind: ROW_SAMPLE, default: '0};
    row.kind    = ROW_SAMPLE;
    row.meas    = meas[SAMPLE_W-1:0];
    row.tgt     = tgt[SAMPLE_W-1:0];
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked(input int meas, input int tgt,
                                      input int drive, input logic gated);
    stim_row_t row;
    row           = '{kind: ROW_SAMPLE, default: '0};
    row.kind      = ROW_SAMPLE;
    row.meas      = meas[SAMPLE_W-1:0];
    row.tgt       = tgt[SAMPLE_W-1:0];
    row.has_exp   = 1'b1;
    row.res.drive = drive[DRIVE_W-1:0];
    row.res.gated = gated;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    stim_row_t row;
    row         = '{kind: ROW_REG, default: '0};
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    stim_rows.push_back(row);
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3, 4:    return $urandom();
      default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32767;
      2:       return $urandom_range(1, 50);
      default: return $urandom_range(1, 32767);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return -16'sd1;
    endcase
  endfunction

  // Called at a falling edge; returns at the first falling edge at which the queue is empty.
  task automatic hold_until_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    hold_until_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    set_model_reg(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] meas,
                             input logic signed [SAMPLE_W-1:0] tgt,
                             input bit has_exp, input pid_result_t exp_res);
    int          gap;
    pid_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {tgt, meas};
    do @(posedge clk); while (!in_tready);
    res = predict_drive(meas, tgt);
    expected_results.push_back(has_exp ? exp_res : res);
    @(negedge clk);
  endtask

  // result side: step through four stall regimes in turn
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      rcv_cycle++;
      case ((rcv_cycle / 300) % 4)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((rcv_cycle % 9) < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: drive %0d gated %0b", $signed(out_tdata), out_tuser);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.drive) begin
          $error("drive mismatch: expected %0d, actual %0d", want.drive, $signed(out_tdata));
          fail_count++;
        end
        if (out_tuser !== want.gated) begin
          $error("gated mismatch: expected %0b, actual %0b", want.gated, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("dual_mode_pid_step_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] meas;
    logic signed [SAMPLE_W-1:0] tgt;
    int                         base;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // after reset: zero gains give zero drive
    add_checked(0, 0, 0, 1'b0);
    add_checked(-32768, 32767, 0, 1'b0);
    add_reg(REG_GAIN_P, 32'h0001_0000);
    add_checked(0, 100, 100, 1'b0);
    add_checked(32767, -32768, -30000, 1'b0);
    // zero and full output limit
    add_reg(REG_OUT_LIM, 0);
    add_checked(-32768, 32767, 0, 1'b0);
    add_reg(REG_OUT_LIM, 32767);
    add_checked(-32768, 32767, 32767, 1'b0);
    // zero integral limit holds the I term at zero
    add_reg(REG_INT_LIM, 0);
    add_reg(REG_GAIN_I, 32'h7FFF_FFFF);
    add_checked(10, 60, 50, 1'b0);
    add_reg(REG_INT_LIM, 32767);
    add_reg(REG_GAIN_P, 32'h0000_8000);
    add_sample(3, 0);
    add_reg(REG_GAIN_I, 32'h8000_0000);
    add_sample(0, 1000);
    add_reg(REG_GAIN_D, 32'h8000_0000);
    add_sample(500, -500);
    add_reg(REG_GAIN_D, 32'h7FFF_FFFF);
    add_sample(-32768, 32767);
    // truncation toward zero at half gain
    add_reg(REG_GAIN_I, 0);
    add_reg(REG_GAIN_D, 0);
    add_reg(REG_INT_LIM, 0);
    add_checked(3, 0, -1, 1'b0);
    add_checked(0, 3, 1, 1'b0);
    // error ceiling and dead band
    add_reg(REG_ERR_CEIL, 100);
    add_checked(0, 101, 0, 1'b1);
    add_checked(100, 0, -50, 1'b0);
    add_reg(REG_DEAD_BAND, 10);
    add_checked(0, 9, 0, 1'b1);
    add_checked(5, 5, 0, 1'b1);
    add_checked(0, -10, -5, 1'b0);
    add_reg(REG_ERR_CEIL, 65535);
    add_reg(REG_DEAD_BAND, 65535);
    add_checked(-32768, 32767, 32767, 1'b0);
    add_checked(32767, -32768, -32767, 1'b0);
    add_checked(0, 1, 0, 1'b1);
    add_reg(REG_ERR_CEIL, 0);
    add_reg(REG_DEAD_BAND, 0);
    // incremental mode, then back to positional on the carried integral
    add_reg(REG_MODE, DATA_W'(MODE_INC));
    add_reg(REG_GAIN_P, 32'h0001_0000);
    add_reg(REG_GAIN_I, 32'h0000_4000);
    add_reg(REG_GAIN_D, 32'h0000_2000);
    add_reg(REG_INT_LIM, 5000);
    add_sample(0, 200);
    add_sample(0, -300);
    add_sample(50, 50);
    add_sample(-32768, 32767);
    add_reg(REG_MODE, DATA_W'(MODE_POS));
    add_sample(0, 40);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        program_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_sample(stim_rows[i].meas, stim_rows[i].tgt, stim_rows[i].has_exp,
                    stim_rows[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      program_reg(REG_MODE, $urandom_range(0, 1));
      program_reg(REG_OUT_LIM, pick_limit());
      program_reg(REG_INT_LIM, pick_limit());
      program_reg(REG_GAIN_P, pick_gain());
      program_reg(REG_GAIN_I, pick_gain());
      program_reg(REG_GAIN_D, pick_gain());
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: program_reg(REG_ERR_CEIL, 0);
        6:                program_reg(REG_ERR_CEIL, 65535);
        7, 8:             program_reg(REG_ERR_CEIL, $urandom_range(100, 2000));
        default:          program_reg(REG_ERR_CEIL, $urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: program_reg(REG_DEAD_BAND, 0);
        5, 6:          program_reg(REG_DEAD_BAND, $urandom_range(1, 64));
        7:             program_reg(REG_DEAD_BAND, 65535);
        default:       program_reg(REG_DEAD_BAND, $urandom_range(1, 65535));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            meas = SAMPLE_W'($urandom());
            tgt  = SAMPLE_W'($urandom());
          end
          3, 4, 5: begin
            meas = pick_extreme();
            tgt  = pick_extreme();
          end
          default: begin
            // small errors around a random operating point
            base = int'($urandom_range(0, 60000)) - 30000;
            meas = SAMPLE_W'(base);
            tgt  = SAMPLE_W'(base + int'($urandom_range(0, 400)) - 200);
          end
        endcase
        if ($urandom_range(0, 199) == 0) hold_until_drained();
        send_sample(meas, tgt, 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("dual_mode_pid_step_top verification clean");
    end else begin
      $display("dual_mode_pid_step_top verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dmpid_pkg.sv
rtl/core/dual_mode_pid_step_top.sv
sim/dual_mode_pid_step_top_tb.sv
